// ===== hdl/rtpms_pkg.sv =====
// Package: shared types, codes and constants for the RTP-MIDI session responder.
`timescale 1ns / 1ps

package rtpms_pkg;

    // Fixed packet limits and reset values
    localparam int unsigned MAX_PACKET_BYTES = 512;
    localparam logic [9:0]  MIN_DATA_BYTES   = 10'd12;
    localparam logic [31:0] TIMEOUT_RESET    = 32'd90000;
    localparam logic [9:0]  MIN_EXCH_RESET   = 10'd16;

    // Packet signatures
    localparam logic [15:0] SIG_EXCHANGE = 16'hffff;
    localparam logic [15:0] SIG_RTP      = 16'h6180;

    // Two-letter exchange commands
    localparam logic [15:0] CMD_IN = 16'h494e;
    localparam logic [15:0] CMD_OK = 16'h4f4b;
    localparam logic [15:0] CMD_NO = 16'h4e4f;
    localparam logic [15:0] CMD_BY = 16'h4259;
    localparam logic [15:0] CMD_CK = 16'h434b;

    // Request kinds
    localparam logic [1:0] REQ_DATA = 2'd0;
    localparam logic [1:0] REQ_CTRL = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;
    localparam logic [1:0] REQ_SEND = 2'd3;

    // Reply kinds
    localparam logic [2:0] RK_NONE        = 3'd0;
    localparam logic [2:0] RK_ACCEPT_CTRL = 3'd1;
    localparam logic [2:0] RK_REJECT_CTRL = 3'd2;
    localparam logic [2:0] RK_ACCEPT_DATA = 3'd3;
    localparam logic [2:0] RK_SYNC        = 3'd4;
    localparam logic [2:0] RK_RTP         = 3'd5;

    // Session phase codes as reported
    localparam logic [1:0] PHC_WAIT_CTRL = 2'd0;
    localparam logic [1:0] PHC_WAIT_DATA = 2'd1;
    localparam logic [1:0] PHC_ESTAB     = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_OWN_SSRC   = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_MS = 2'd1;
    localparam logic [1:0] CFG_MIN_EXCH   = 2'd2;

    // Session state machine
    typedef enum logic [2:0] {
        PH_WAIT_CTRL = 3'b001,
        PH_WAIT_DATA = 3'b010,
        PH_ESTAB     = 3'b100
    } t_phase;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [9:0]  byte_count;
        logic [15:0] first_word;
        logic [15:0] command_code;
        logic [31:0] sender_ip;
        logic [15:0] sender_port;
        logic [31:0] initiator_token;
        logic [7:0]  sync_count;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  reply_kind;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [31:0] token_echo;
        logic [1:0]  sync_count_out;
        logic [1:0]  stamp_slot;
        logic [31:0] stamp_value;
        logic        send_granted;
        logic [1:0]  session_phase;
        logic        session_closed;
    } t_out_item;

    typedef struct packed {
        logic [31:0] own_ssrc;
        logic [31:0] timeout_ms;
        logic [9:0]  min_exchange_bytes;
    } t_cfg;

    // Map the one-hot phase to its reported code
    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        case (ph)
            PH_WAIT_DATA: code = PHC_WAIT_DATA;
            PH_ESTAB:     code = PHC_ESTAB;
            default:      code = PHC_WAIT_CTRL;
        endcase
        return code;
    endfunction

endpackage

// ===== hdl/rtpms_cfg_regs.sv =====
// Configuration register file of the session responder.
`timescale 1ns / 1ps

module rtpms_cfg_regs import rtpms_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [1:0]  i_index,
    input  logic [31:0] i_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write; drop writes to unknown indexes
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_index)
                CFG_OWN_SSRC:   n_cfg.own_ssrc           = i_data;
                CFG_TIMEOUT_MS: n_cfg.timeout_ms         = i_data;
                CFG_MIN_EXCH:   n_cfg.min_exchange_bytes = i_data[9:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_ssrc           <= '0;
            r_cfg.timeout_ms         <= TIMEOUT_RESET;
            r_cfg.min_exchange_bytes <= MIN_EXCH_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/rtpms_session_core.sv =====
// Session state registers and the per-transaction reply decision logic.
`timescale 1ns / 1ps

module rtpms_session_core import rtpms_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_peer_address, n_peer_address;
    logic [15:0] r_peer_data_port, n_peer_data_port;
    logic [31:0] r_last_sync_ms, n_last_sync_ms;
    logic [31:0] r_ms_clock, n_ms_clock;

    logic [9:0]  len;
    logic        exch;
    logic        data_ok;
    logic [31:0] elapsed;
    logic [1:0]  cnt_next;
    t_out_item   res;

    // Clamp the length, then qualify exchange and data packets
    always_comb begin
        if (32'(i_item.byte_count) > 32'(MAX_PACKET_BYTES)) begin
            len = 10'(MAX_PACKET_BYTES);
        end else begin
            len = i_item.byte_count;
        end
        exch    = (len >= i_cfg.min_exchange_bytes) && (i_item.first_word == SIG_EXCHANGE);
        data_ok = (len >= MIN_DATA_BYTES) && (i_item.sender_ip == r_peer_address);
        elapsed = (r_ms_clock + 32'd1) - r_last_sync_ms;
        cnt_next = (i_item.sync_count[1:0] == 2'd2) ? 2'd0 : i_item.sync_count[1:0] + 2'd1;
    end

    // Decide the reply and the next session state
    always_comb begin
        n_phase          = r_phase;
        n_peer_address   = r_peer_address;
        n_peer_data_port = r_peer_data_port;
        n_last_sync_ms   = r_last_sync_ms;
        n_ms_clock       = r_ms_clock;
        res              = '0;

        case (i_item.req_type)
            REQ_DATA: begin
                if (data_ok) begin
                    if (i_item.first_word == SIG_RTP) begin
                        res.reply_kind = RK_RTP;
                    end else if (exch) begin
                        if (r_phase == PH_WAIT_DATA) begin
                            if (i_item.command_code == CMD_IN) begin
                                res.reply_kind   = RK_ACCEPT_DATA;
                                res.dest_ip      = i_item.sender_ip;
                                res.dest_port    = i_item.sender_port;
                                res.token_echo   = i_item.initiator_token;
                                n_phase          = PH_ESTAB;
                                n_peer_data_port = i_item.sender_port;
                                n_last_sync_ms   = r_ms_clock;
                            end
                        end else if (r_phase == PH_ESTAB && i_item.command_code == CMD_CK) begin
                            n_last_sync_ms = r_ms_clock;
                            if (i_item.sync_count <= 8'd2) begin
                                res.reply_kind     = RK_SYNC;
                                res.dest_ip        = i_item.sender_ip;
                                res.dest_port      = i_item.sender_port;
                                res.sync_count_out = cnt_next;
                                res.stamp_slot     = cnt_next;
                                // times ten as two shifts and an add
                                res.stamp_value    = (r_ms_clock << 3) + (r_ms_clock << 1);
                            end
                        end
                    end
                end
            end
            REQ_CTRL: begin
                if (exch) begin
                    if (r_phase == PH_WAIT_CTRL) begin
                        if (r_peer_address == '0 && i_item.command_code == CMD_IN) begin
                            res.reply_kind = RK_ACCEPT_CTRL;
                            res.dest_ip    = i_item.sender_ip;
                            res.dest_port  = i_item.sender_port;
                            res.token_echo = i_item.initiator_token;
                            n_phase        = PH_WAIT_DATA;
                            n_peer_address = i_item.sender_ip;
                        end
                    end else if (r_phase == PH_ESTAB) begin
                        if (r_peer_address == i_item.sender_ip
                                && i_item.command_code == CMD_BY) begin
                            n_phase            = PH_WAIT_CTRL;
                            n_peer_address     = '0;
                            res.session_closed = 1'b1;
                        end else if (i_item.command_code == CMD_IN) begin
                            res.reply_kind = RK_REJECT_CTRL;
                            res.dest_ip    = i_item.sender_ip;
                            res.dest_port  = i_item.sender_port;
                            res.token_echo = i_item.initiator_token;
                        end
                    end
                end
            end
            REQ_TICK: begin
                // Advance the clock; drop an established session gone quiet
                n_ms_clock = r_ms_clock + 32'd1;
                if (r_phase == PH_ESTAB && elapsed > i_cfg.timeout_ms) begin
                    n_phase            = PH_WAIT_CTRL;
                    n_peer_address     = '0;
                    res.session_closed = 1'b1;
                end
            end
            REQ_SEND: begin
                if (r_phase == PH_ESTAB) begin
                    res.send_granted = 1'b1;
                    res.dest_ip      = r_peer_address;
                    res.dest_port    = r_peer_data_port;
                end
            end
            default: begin
                res = '0;
            end
        endcase

        res.session_phase = phase_code(n_phase);
    end

    // Commit state when a transaction is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_WAIT_CTRL;
            r_peer_address   <= '0;
            r_peer_data_port <= '0;
            r_last_sync_ms   <= '0;
            r_ms_clock       <= '0;
        end else if (i_fire) begin
            r_phase          <= n_phase;
            r_peer_address   <= n_peer_address;
            r_peer_data_port <= n_peer_data_port;
            r_last_sync_ms   <= n_last_sync_ms;
            r_ms_clock       <= n_ms_clock;
        end
    end

    assign o_result = res;

    // A session waiting on control never holds a peer address
    a_idle_no_peer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_WAIT_CTRL |-> r_peer_address == '0)
        else $error("peer address held while waiting on control");

    // A closing transaction always leaves the session waiting on control
    a_close_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.session_closed |=> r_phase == PH_WAIT_CTRL)
        else $error("session closed but phase not reset");

    // A data accept always establishes the session
    a_accept_estab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.reply_kind == RK_ACCEPT_DATA |=> r_phase == PH_ESTAB)
        else $error("data accept without establishing session");

    // Only a tick advances the millisecond clock
    a_clock_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.req_type != REQ_TICK |=> $stable(r_ms_clock))
        else $error("millisecond clock moved without a tick");

endmodule

// ===== hdl/rtp_midi_session_responder_unit.sv =====
// Top level of the RTP-MIDI session responder: handshakes, input and result registers.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one request per
//   transaction: a parsed data-port or control-port header, a millisecond tick,
//   or a send query. Output channel (o_out_valid / i_out_stall / o_out_data)
//   returns exactly one reply decision per request, in order.
//   Configuration port (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   writes own_ssrc (0), timeout_ms (1) and min_exchange_bytes (2); it is
//   always ready, and writes are to be made only while the block is idle.
//   A request accepted into the input register reaches o_out_data through the
//   result register. Throughput: one request per cycle while i_out_stall is
//   low; the decision is one pass of compares and a 32-bit subtract/compare
//   between the input and result registers.
//   Reset (i_rst_n low, synchronous) empties both registers, returns the
//   session to waiting on control and loads the configuration defaults.
//   When the receiver stalls, the reply holds in the result register, the
//   input register fills once more, and then o_in_stall rises until space frees.
`timescale 1ns / 1ps

module rtp_midi_session_responder_unit import rtpms_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      out_adv;
    logic      in_adv;
    logic      fire;
    t_cfg      cfg;
    t_out_item result;

    // Advance the result register when empty or drained; the input register follows
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign in_adv     = !r_in_valid || out_adv;
    assign fire       = r_in_valid && out_adv;
    assign o_in_stall = !in_adv;
    assign o_cfg_ready = 1'b1;

    rtpms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    rtpms_session_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register: hold the transaction until the core takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    // Result register: load the decision, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // Input side only stalls when both registers are occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with free register");

    // A processed transaction always lands as a valid result
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed transaction lost");

    // A result held under stall keeps the input transaction parked
    a_park: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && i_out_stall |=> r_in_valid && $stable(r_in_item))
        else $error("pending transaction dropped during stall");

endmodule
